### rtl/response_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Response frame receiver assertion macros
// Shared helpers for concurrent checks on the receiver ports.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_RECEIVER_DEFINES_SVH
`define RESPONSE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("response_frame_receiver check failed");

// Next-cycle implication, disabled while reset is high.
`define RFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("response_frame_receiver check failed");

`endif

### rtl/rfr_pkg.sv
// ----------------------------------------------------------------------------
// Response frame receiver package
// Field widths, event and status codes, and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

  localparam int RFR_MAX_BYTES_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_OUT_W = 7;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 16;
  localparam int TICK_W   = 9;

  localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hEF;
  localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'h01;
  localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd60;
  localparam logic [TICK_W-1:0] TICK_SAT    = 9'h100;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_ABORT = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADSUM   = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_ABORT    = 3'd4
  } status_t;

  typedef struct packed {
    logic                 byte_valid;
    logic [IDX_OUT_W-1:0] byte_index;
    logic [BYTE_W-1:0]    byte_value;
    logic                 done_res;
    status_t              status;
    logic [IDX_OUT_W-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

endpackage

`default_nettype wire

### rtl/rfr_in_stage.sv
// ----------------------------------------------------------------------------
// Response frame receiver input stage
// Registers one incoming word and hands it to the frame logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rfr_pkg::item_t in_item,
  output logic               item_valid,
  output rfr_pkg::item_t     item,
  input  wire logic          item_take
);
  import rfr_pkg::*;

  logic held;

  assign in_ready   = !held || item_take;
  assign item_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/rfr_frame_core.sv
// ----------------------------------------------------------------------------
// Response frame receiver frame logic
// Holds the reception state and turns one word into one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_frame_core #(
  parameter int MAX_BYTES = rfr_pkg::RFR_MAX_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write_en,
  input  wire logic [rfr_pkg::BYTE_W-1:0]  cfg_write_data,
  input  wire rfr_pkg::item_t              item,
  input  wire logic                        step,
  output rfr_pkg::result_t                 res
);
  import rfr_pkg::*;

  localparam int IDX_W = $clog2(MAX_BYTES + 1);
  localparam int CMP_W = LEN_W + 1;
  localparam logic [IDX_W:0] MAX_C = (IDX_W + 1)'(MAX_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HUNT   = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  index, index_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic              length_known, length_known_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] previous_byte, previous_byte_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [BYTE_W-1:0] timeout_ticks;

  logic [IDX_W:0]    idx_inc;
  logic [IDX_W-1:0]  idx_body;
  logic [TICK_W-1:0] tick_inc;
  logic [BYTE_W-1:0] chk;
  logic [IDX_W+IDX_OUT_W-1:0] idx_ext, body_ext, max_ext;
  logic [CMP_W+IDX_W-1:0]     body_cmp;
  logic [CMP_W-1:0]           end_at;
  logic [LEN_W-1:0]  len_body;
  logic              known_body;
  logic              end_hit;
  logic [BYTE_W-1:0] b;

  assign b        = item.rx_byte;
  assign idx_inc  = {1'b0, index} + (IDX_W + 1)'(1);
  assign idx_body = idx_inc[IDX_W-1:0];
  assign tick_inc = (tick_count < TICK_SAT) ? tick_count + TICK_W'(1) : tick_count;
  assign chk      = running_sum - previous_byte;
  assign idx_ext  = {{IDX_OUT_W{1'b0}}, index};
  assign body_ext = {{IDX_OUT_W{1'b0}}, idx_body};
  assign max_ext  = {{IDX_OUT_W{1'b0}}, MAX_C[IDX_W-1:0]};
  assign body_cmp = {{CMP_W{1'b0}}, idx_body};

  // Length as it stands once the current body byte is taken in.
  assign len_body   = (idx_body == IDX_W'(7)) ? {b, frame_length[BYTE_W-1:0]} :
                      (idx_body == IDX_W'(8)) ? {frame_length[LEN_W-1:BYTE_W], b} :
                      frame_length;
  assign known_body = length_known || (idx_body == IDX_W'(8));
  assign end_at     = {1'b0, len_body} + CMP_W'(8);
  assign end_hit    = known_body && (body_cmp[CMP_W-1:0] == end_at);

  always_comb begin
    phase_next         = phase;
    index_next         = index;
    frame_length_next  = frame_length;
    length_known_next  = length_known;
    running_sum_next   = running_sum;
    previous_byte_next = previous_byte;
    tick_count_next    = tick_count;
    res                = '0;

    if (item.func == FUNC_START) begin
      phase_next         = PH_HUNT;
      index_next         = '0;
      frame_length_next  = '0;
      length_known_next  = 1'b0;
      running_sum_next   = '0;
      previous_byte_next = '0;
      tick_count_next    = '0;
    end else if (phase != PH_IDLE) begin
      case (item.func)
        FUNC_ABORT: begin
          phase_next     = PH_IDLE;
          res.done_res   = 1'b1;
          res.status     = ST_ABORT;
          res.byte_count = idx_ext[IDX_OUT_W-1:0];
        end
        FUNC_TICK: begin
          tick_count_next = tick_inc;
          if (tick_inc > {1'b0, timeout_ticks}) begin
            phase_next     = PH_IDLE;
            res.done_res   = 1'b1;
            res.status     = ST_TIMEOUT;
            res.byte_count = idx_ext[IDX_OUT_W-1:0];
          end
        end
        FUNC_BYTE: begin
          if (phase != PH_BODY) begin
            // Header hunt: 0xEF always restarts the header at index zero.
            if (b == HDR_FIRST) begin
              index_next     = '0;
              phase_next     = PH_HEADER;
              res.byte_valid = 1'b1;
              res.byte_value = b;
            end else if (phase == PH_HEADER && b == HDR_SECOND) begin
              index_next     = IDX_W'(1);
              phase_next     = PH_BODY;
              res.byte_valid = 1'b1;
              res.byte_index = IDX_OUT_W'(1);
              res.byte_value = b;
            end else begin
              index_next = '0;
              phase_next = PH_HUNT;
            end
          end else if (idx_inc > MAX_C) begin
            phase_next     = PH_IDLE;
            res.done_res   = 1'b1;
            res.status     = ST_OVERFLOW;
            res.byte_count = max_ext[IDX_OUT_W-1:0];
          end else begin
            index_next = idx_body;
            if (idx_body >= IDX_W'(6)) begin
              running_sum_next = running_sum + b;
            end
            if (idx_body == IDX_W'(7)) begin
              frame_length_next = {b, frame_length[BYTE_W-1:0]};
            end
            if (idx_body == IDX_W'(8)) begin
              frame_length_next = {frame_length[LEN_W-1:BYTE_W], b};
              length_known_next = 1'b1;
            end
            previous_byte_next = b;
            res.byte_valid     = 1'b1;
            res.byte_index     = body_ext[IDX_OUT_W-1:0];
            res.byte_value     = b;
            // The last byte carries the sum of the bytes from index six up to the one two places before it.
            if (end_hit) begin
              phase_next     = PH_IDLE;
              res.done_res   = 1'b1;
              res.status     = (chk == b) ? ST_OK : ST_BADSUM;
              res.byte_count = body_ext[IDX_OUT_W-1:0];
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      index         <= '0;
      frame_length  <= '0;
      length_known  <= 1'b0;
      running_sum   <= '0;
      previous_byte <= '0;
      tick_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      index         <= index_next;
      frame_length  <= frame_length_next;
      length_known  <= length_known_next;
      running_sum   <= running_sum_next;
      previous_byte <= previous_byte_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_write_en) begin
      timeout_ticks <= cfg_write_data;
    end
  end

endmodule

`default_nettype wire

### rtl/rfr_out_stage.sv
// ----------------------------------------------------------------------------
// Response frame receiver output stage
// Result register that decouples the frame logic from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rfr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load_valid,
  output logic                  load_ready,
  input  wire rfr_pkg::result_t load_res,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rfr_pkg::result_t      out_res
);
  import rfr_pkg::*;

  logic full;

  assign load_ready = !full || out_ready;
  assign out_valid  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load_ready) begin
      full <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

### rtl/response_frame_receiver.sv
// ----------------------------------------------------------------------------
// Response frame receiver
// Header hunt, length-prefixed framing and sum check for sensor replies.
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one result word. The block takes one word
// per clock cycle while the result register is free or being read, as the whole
// frame state update for a word is combinational between the input register
// and the result register. A word's result moves from the input register into
// the result register once that one is free or being read, and is held there
// until taken. A stalled result register holds back the input once the input
// register is also occupied, so up to two words can wait inside the block.
// timeout_ticks may be written when no words are in flight.
`default_nettype none

module response_frame_receiver #(
  parameter int MAX_BYTES = rfr_pkg::RFR_MAX_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [rfr_pkg::BYTE_W-1:0]    cfg_write_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rfr_pkg::FUNC_W-1:0]    func,
  input  wire logic [rfr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               byte_valid,
  output logic [rfr_pkg::IDX_OUT_W-1:0]      byte_index,
  output logic [rfr_pkg::BYTE_W-1:0]         byte_value,
  output logic                               done_res,
  output logic [rfr_pkg::STATUS_W-1:0]       status,
  output logic [rfr_pkg::IDX_OUT_W-1:0]      byte_count
);
  import rfr_pkg::*;

  item_t   in_item, item;
  logic    item_valid, load_ready, step;
  result_t core_res, out_res;

  assign in_item.func    = func;
  assign in_item.rx_byte = rx_byte;
  assign step            = item_valid && load_ready;

  rfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (load_ready)
  );

  rfr_frame_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item),
    .step           (step),
    .res            (core_res)
  );

  rfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_valid),
    .load_ready (load_ready),
    .load_res   (core_res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign byte_valid = out_res.byte_valid;
  assign byte_index = out_res.byte_index;
  assign byte_value = out_res.byte_value;
  assign done_res   = out_res.done_res;
  assign status     = out_res.status;
  assign byte_count = out_res.byte_count;

endmodule

`default_nettype wire

### rtl/rfr_checker.sv
// ----------------------------------------------------------------------------
// Response frame receiver checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "response_frame_receiver_defines.svh"

module rfr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          byte_valid,
  input wire logic [rfr_pkg::IDX_OUT_W-1:0] byte_index,
  input wire logic [rfr_pkg::BYTE_W-1:0]    byte_value,
  input wire logic                          done_res,
  input wire logic [rfr_pkg::STATUS_W-1:0]  status,
  input wire logic [rfr_pkg::IDX_OUT_W-1:0] byte_count
);
  import rfr_pkg::*;

  // A stalled result word stays put.
  `RFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_value) && $stable(status) && $stable(byte_count))

  // Byte fields are zero unless a byte was stored.
  `RFR_ASSERT_NOW(a_byte_zero, clk, rst, out_valid && !byte_valid, byte_index == '0 && byte_value == '0)

  // Status and count are zero unless the frame ended.
  `RFR_ASSERT_NOW(a_done_zero, clk, rst, out_valid && !done_res, status == ST_OK && byte_count == '0)

  // A frame that ends on a stored byte ends with the sum check.
  `RFR_ASSERT_NOW(a_end_sum, clk, rst, out_valid && byte_valid && done_res, status == ST_OK || status == ST_BADSUM)

  // Frame ends never report a code beyond abort.
  `RFR_ASSERT_NOW(a_status_rng, clk, rst, out_valid && done_res, status == ST_OK || status == ST_BADSUM || status == ST_TIMEOUT || status == ST_OVERFLOW || status == ST_ABORT)

endmodule

bind response_frame_receiver rfr_checker u_rfr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .byte_valid (byte_valid),
  .byte_index (byte_index),
  .byte_value (byte_value),
  .done_res   (done_res),
  .status     (status),
  .byte_count (byte_count)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response frame receiver testbench
// A short table of directed words, then random reply frames with random
// content. A software copy of the receiver predicts the result of every
// accepted word; results are checked in order, field by field.
// ----------------------------------------------------------------------------

module testbench;
  import rfr_pkg::*;

  localparam int MAX_FRAME = RFR_MAX_BYTES_DEF;

  typedef enum logic [1:0] {RX_IDLE, RX_HUNT, RX_SYNC, RX_BODY} rx_phase_t;

  typedef struct {
    item_t   w;
    bit      pinned;
    result_t res;
  } row_t;

  typedef struct {
    bit      pinned;
    result_t res;
  } pin_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [BYTE_W-1:0] cfg_write_data;
  logic in_valid;
  logic in_ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] rx_byte;
  logic out_valid;
  logic out_ready = 1'b0;
  logic byte_valid;
  logic [IDX_OUT_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic done_res;
  logic [STATUS_W-1:0] status;
  logic [IDX_OUT_W-1:0] byte_count;

  // Predicted receiver state.
  rx_phase_t rx_phase;
  int rx_index;
  logic [LEN_W-1:0] frame_len;
  bit len_known;
  logic [BYTE_W-1:0] chk_sum;
  logic [BYTE_W-1:0] last_byte;
  int tick_cnt;
  logic [BYTE_W-1:0] timeout_cfg = TIMEOUT_RST;

  result_t pending_results[$];
  pin_t pinned_q[$];
  item_t stim_q[$];
  row_t dir_rows[$];

  int errors = 0;
  int words_in = 0;
  int ended [5] = '{default: 0};
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int ready_hold = 0;

  always #1 clk = ~clk;

  response_frame_receiver uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_valid(byte_valid),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .done_res(done_res),
    .status(status),
    .byte_count(byte_count)
  );

  function automatic void arm_frame();
    rx_phase = RX_HUNT;
    rx_index = 0;
    frame_len = '0;
    len_known = 1'b0;
    chk_sum = '0;
    last_byte = '0;
    tick_cnt = 0;
  endfunction

  function automatic result_t mk_res(input logic valid, input int idx, input logic [7:0] val,
                                     input logic done, input status_t st, input int cnt);
    result_t r;
    r.byte_valid = valid;
    r.byte_index = IDX_OUT_W'(idx);
    r.byte_value = val;
    r.done_res = done;
    r.status = st;
    r.byte_count = IDX_OUT_W'(cnt);
    return r;
  endfunction

  // Advances the predicted receiver by one word and returns its result.
  function automatic result_t frame_step(input func_t f, input logic [BYTE_W-1:0] b);
    result_t r;
    logic [BYTE_W-1:0] sum_prev;
    r = '0;
    if (f == FUNC_START) begin
      arm_frame();
      return r;
    end
    if (rx_phase == RX_IDLE) return r;
    if (f == FUNC_ABORT) begin
      rx_phase = RX_IDLE;
      r = mk_res(1'b0, 0, 8'h00, 1'b1, ST_ABORT, rx_index);
    end else if (f == FUNC_TICK) begin
      if (tick_cnt < int'(TICK_SAT)) tick_cnt++;
      if (tick_cnt > int'(timeout_cfg)) begin
        rx_phase = RX_IDLE;
        r = mk_res(1'b0, 0, 8'h00, 1'b1, ST_TIMEOUT, rx_index);
      end
    end else if (rx_phase != RX_BODY) begin
      if (b == HDR_FIRST) begin
        rx_index = 0;
        rx_phase = RX_SYNC;
        r = mk_res(1'b1, 0, b, 1'b0, ST_OK, 0);
      end else if (rx_phase == RX_SYNC && b == HDR_SECOND) begin
        rx_index = 1;
        rx_phase = RX_BODY;
        r = mk_res(1'b1, 1, b, 1'b0, ST_OK, 0);
      end else begin
        rx_index = 0;
        rx_phase = RX_HUNT;
      end
    end else if (rx_index + 1 > MAX_FRAME) begin
      // The buffer is full: the word is dropped and the frame ends.
      rx_phase = RX_IDLE;
      r = mk_res(1'b0, 0, 8'h00, 1'b1, ST_OVERFLOW, MAX_FRAME);
    end else begin
      rx_index++;
      sum_prev = chk_sum;
      if (rx_index >= 6) chk_sum = chk_sum + b;
      if (rx_index == 7) frame_len[15:8] = b;
      if (rx_index == 8) begin
        frame_len[7:0] = b;
        len_known = 1'b1;
      end
      r = mk_res(1'b1, rx_index, b, 1'b0, ST_OK, 0);
      if (len_known && rx_index == int'(frame_len) + 8) begin
        // The running sum still holds the word before this one; take it back out.
        rx_phase = RX_IDLE;
        r.done_res = 1'b1;
        r.status = (BYTE_W'(sum_prev - last_byte) == b) ? ST_OK : ST_BADSUM;
        r.byte_count = IDX_OUT_W'(rx_index);
      end
      last_byte = b;
    end
    if (r.done_res) ended[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d, expected %0d",
             words_in - pending_results.size(), what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : take_words
    pin_t p;
    result_t r;
    if (!rst && in_valid && in_ready) begin
      r = frame_step(func_t'(func), rx_byte);
      p = pinned_q.pop_front();
      pending_results.push_back(p.pinned ? p.res : r);
      words_in++;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", byte_valid, want.byte_valid);
        if (byte_index !== want.byte_index)
          report_mismatch("byte_index", byte_index, want.byte_index);
        if (byte_value !== want.byte_value)
          report_mismatch("byte_value", byte_value, want.byte_value);
        if (done_res !== want.done_res)
          report_mismatch("done_res", done_res, want.done_res);
        if (status !== want.status)
          report_mismatch("status", status, int'(want.status));
        if (byte_count !== want.byte_count)
          report_mismatch("byte_count", byte_count, want.byte_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (recv_idle && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void row(input func_t f, input logic [7:0] b, input bit pinned,
                              input result_t res);
    row_t rw;
    rw.w.func = f;
    rw.w.rx_byte = b;
    rw.pinned = pinned;
    rw.res = res;
    dir_rows.push_back(rw);
  endfunction

  function automatic void push_word(input func_t f, input logic [7:0] b);
    item_t w;
    w.func = f;
    w.rx_byte = b;
    stim_q.push_back(w);
  endfunction

  // One reply frame, mostly well formed, sometimes cut short, aborted or overlong.
  task automatic queue_frame();
    logic [7:0] fb [MAX_FRAME+2];
    logic [7:0] csum;
    int len;
    int total;
    int last;
    int cut;
    int pick;
    push_word(FUNC_START, 8'($urandom));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_word(FUNC_BYTE, 8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      pick = $urandom_range(0, 255);
      if (pick == int'(HDR_SECOND)) pick = 0;
      push_word(FUNC_BYTE, HDR_FIRST);
      push_word(FUNC_BYTE, 8'(pick));
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 12);
    else if (pick < 85) len = $urandom_range(13, MAX_FRAME - 8);
    else if (pick < 95) len = $urandom_range(MAX_FRAME - 7, MAX_FRAME + 6);
    else len = $urandom_range(0, 65535);
    total = len + 8;
    last = (total > MAX_FRAME) ? MAX_FRAME + 1 : total;
    foreach (fb[i]) fb[i] = 8'($urandom);
    fb[0] = HDR_FIRST;
    fb[1] = HDR_SECOND;
    fb[7] = len[15:8];
    fb[8] = len[7:0];
    if (total > 8 && total <= MAX_FRAME && $urandom_range(0, 9) < 8) begin
      csum = '0;
      for (int i = 6; i <= total - 2; i++) csum = csum + fb[i];
      fb[total] = csum;
    end
    cut = last;
    pick = $urandom_range(0, 99);
    if (pick < 12) cut = $urandom_range(0, last);
    for (int i = 0; i <= cut; i++) begin
      if ($urandom_range(0, 15) == 0) push_word(FUNC_TICK, 8'($urandom));
      push_word(FUNC_BYTE, fb[i]);
    end
    if (pick < 8) push_word(FUNC_ABORT, 8'($urandom));
    if ($urandom_range(0, 7) == 0) push_word(func_t'($urandom_range(1, 3)), 8'($urandom));
  endtask

  task automatic send_word(input item_t w, input bit pinned, input result_t res);
    pin_t p;
    p.pinned = pinned;
    p.res = res;
    pinned_q.push_back(p);
    if (send_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= w.func;
    rx_byte <= w.rx_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    timeout_cfg = v;
    cfg_write_en <= 1'b0;
  endtask

  initial begin : main
    logic [7:0] tmo;
    int target;
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    func <= FUNC_START;
    rx_byte <= '0;
    arm_frame();
    rx_phase = RX_IDLE;

    // Directed words; the first ones hit the receiver while it is idle.
    row(FUNC_BYTE,  8'h55, 1, '0);
    row(FUNC_TICK,  8'h00, 1, '0);
    row(FUNC_ABORT, 8'h00, 1, '0);
    row(FUNC_START, 8'hAA, 1, '0);
    row(FUNC_BYTE,  8'h00, 1, '0);
    row(FUNC_BYTE,  8'hEF, 1, mk_res(1, 0, 8'hEF, 0, ST_OK, 0));
    row(FUNC_BYTE,  8'hEF, 1, mk_res(1, 0, 8'hEF, 0, ST_OK, 0));
    row(FUNC_BYTE,  8'h7F, 1, '0);
    row(FUNC_BYTE,  8'hEF, 1, mk_res(1, 0, 8'hEF, 0, ST_OK, 0));
    row(FUNC_BYTE,  8'h01, 1, mk_res(1, 1, 8'h01, 0, ST_OK, 0));
    repeat (4) row(FUNC_BYTE, 8'hFF, 0, '0);
    row(FUNC_BYTE,  8'h07, 0, '0);
    row(FUNC_BYTE,  8'h00, 0, '0);
    row(FUNC_BYTE,  8'h03, 0, '0);
    row(FUNC_BYTE,  8'h80, 0, '0);
    row(FUNC_BYTE,  8'h00, 0, '0);
    row(FUNC_BYTE,  8'h8A, 0, '0);
    row(FUNC_START, 8'h00, 1, '0);
    row(FUNC_ABORT, 8'hFF, 1, mk_res(0, 0, 8'h00, 1, ST_ABORT, 0));
    row(FUNC_START, 8'hFF, 1, '0);
    row(FUNC_BYTE,  8'hEF, 1, mk_res(1, 0, 8'hEF, 0, ST_OK, 0));
    row(FUNC_BYTE,  8'h01, 1, mk_res(1, 1, 8'h01, 0, ST_OK, 0));
    row(FUNC_ABORT, 8'h00, 1, mk_res(0, 0, 8'h00, 1, ST_ABORT, 1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[k]) send_word(dir_rows[k].w, dir_rows[k].pinned, dir_rows[k].res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph != 4) && (ph != 5);
      recv_idle = (ph != 3) && (ph != 5);
      case (ph)
        0: tmo = 8'd0;
        1: tmo = 8'd255;
        2: tmo = 8'd3;
        4: tmo = TIMEOUT_RST;
        default: tmo = 8'($urandom);
      endcase
      write_timeout(tmo);
      // A run of ticks that just reaches the timeout.
      push_word(FUNC_START, 8'($urandom));
      repeat (int'(tmo) + 1) push_word(FUNC_TICK, 8'($urandom));
      target = stim_q.size() + 200;
      while (stim_q.size() < target) queue_frame();
      while (stim_q.size() != 0) send_word(stim_q.pop_front(), 1'b0, '0);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("summary: %0d words, timeout settings incl. 0, 3 and 255", words_in);
    $display("summary: frames ok %0d, bad sum %0d, timeout %0d, overflow %0d, aborted %0d",
             ended[ST_OK], ended[ST_BADSUM], ended[ST_TIMEOUT], ended[ST_OVERFLOW],
             ended[ST_ABORT]);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still expected", pending_results.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### response_frame_receiver.f
+incdir+rtl
rtl/rfr_pkg.sv
rtl/rfr_in_stage.sv
rtl/rfr_frame_core.sv
rtl/rfr_out_stage.sv
rtl/response_frame_receiver.sv
rtl/rfr_checker.sv
tb/sv/testbench.sv
